FILE: hw/rtl/lru_pkg.sv
// Shared types and constants for the LRU key tracker.
`timescale 1ns / 1ps
package lru_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    KIND_TOUCH  = 3'd0,
    KIND_POP    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_LIST   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [6:0]  list_limit;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [6:0]  occupancy;
    logic        last;
  } rsp_t;

  // One write to a slot's record: key plus both links.
  typedef struct packed {
    logic [31:0]      key;
    logic [IDX_W-1:0] newer;
    logic [IDX_W-1:0] older;
  } slot_t;
endpackage

FILE: hw/rtl/lru_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface lru_req_if;
  import lru_pkg::*;
  logic valid;
  logic ready;
  logic [2:0]  kind;
  logic [31:0] key;
  logic [6:0]  list_limit;
  modport source (output valid, kind, key, list_limit, input ready);
  modport sink (input valid, kind, key, list_limit, output ready);
endinterface

interface lru_rsp_if;
  logic valid;
  logic ready;
  logic [1:0]  status;
  logic [31:0] key_out;
  logic [6:0]  occupancy;
  logic        last;
  modport source (output valid, status, key_out, occupancy, last, input ready);
  modport sink (input valid, status, key_out, occupancy, last, output ready);
endinterface

FILE: hw/rtl/lru_key_tracker_top.sv
// Top level of the LRU key tracker: channels, slot RAM and sequencer.
`timescale 1ns / 1ps
// Find, full touch and empty pop pass the scan and decide states, then give their beat.
// Touch, pop and remove relink through the slot RAM, reading and writing the records
// in turn; the registered read data of the slot RAM sets this order of states.
// A list emits one beat per key walked, one RAM read per key, each beat held until taken.
// One request is in flight at a time; the next is taken once its last beat goes.
// Synchronous reset empties the tracker; slot RAM contents are not cleared.
module lru_key_tracker_top (
  input  logic     clk,
  input  logic     rst,
  lru_req_if.sink  req,
  lru_rsp_if.source rsp
);
  import lru_pkg::*;

  req_t             r;
  rsp_t             o;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  slot_t            wdata, rdata;

  assign r.kind = req.kind;
  assign r.key = req.key;
  assign r.list_limit = req.list_limit;
  assign rsp.status = o.status;
  assign rsp.key_out = o.key_out;
  assign rsp.occupancy = o.occupancy;
  assign rsp.last = o.last;

  // Slot record store: key plus older/newer links.
  lru_ram #(.WIDTH($bits(slot_t)), .DEPTH(ENTRIES)) u_slots (
    .clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rdata)
  );

  lru_ctrl u_ctrl (
    .clk, .rst,
    .req_valid(req.valid), .req_ready(req.ready), .req(r),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(o),
    .ram_we(we), .ram_waddr(waddr), .ram_wdata(wdata),
    .ram_raddr(raddr), .ram_rdata(rdata)
  );
endmodule

FILE: hw/rtl/lru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/lru_ctrl.sv
// Sequencer: key search, relink read-modify-write and list walk over the slot RAM.
`timescale 1ns / 1ps
module lru_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  lru_pkg::req_t           req,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output lru_pkg::rsp_t           rsp,
  output logic                    ram_we,
  output logic [lru_pkg::IDX_W-1:0] ram_waddr,
  output lru_pkg::slot_t          ram_wdata,
  output logic [lru_pkg::IDX_W-1:0] ram_raddr,
  input  lru_pkg::slot_t          ram_rdata
);
  import lru_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RD_O, S_WR_O, S_RD_N, S_WR_N,
    S_ATTACH, S_LIST, S_OUT
  } state_t;

  // Keys are mirrored in a register file for the parallel compare.
  logic [31:0]       cam_key [ENTRIES];
  logic [ENTRIES-1:0] valid;
  state_t            state;
  req_t              cur;
  logic [IDX_W-1:0]  newest, oldest;
  logic [CNT_W-1:0]  count;
  logic [ENTRIES-1:0] match;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx, free_idx;
  logic              has_free;
  logic [IDX_W-1:0]  tgt, lnk_o, lnk_n;
  logic              reattach;
  logic [IDX_W-1:0]  walk;
  logic [4:0]        remain;
  logic              rd_pend;
  rsp_t              out;

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    has_free = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (cam_key[i] == cur.key);
      if (match[i]) hit_idx = IDX_W'(i);
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
        has_free = 1'b1;
      end
    end
    hit = |match;
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp = out;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = tgt;
    ram_wdata = ram_rdata;
    ram_raddr = tgt;
    unique case (state)
      // Fetch the record of the slot about to be detached.
      S_DECIDE: ram_raddr = (cur.kind == KIND_POP) ? oldest : hit_idx;
      S_RD_O: ram_raddr = ram_rdata.older;
      S_WR_O: begin
        ram_we = 1'b1;
        ram_waddr = lnk_o;
        ram_wdata.newer = lnk_n;
      end
      S_RD_N: ram_raddr = lnk_n;
      S_WR_N: begin
        ram_we = 1'b1;
        ram_waddr = lnk_n;
        ram_wdata.older = lnk_o;
      end
      S_ATTACH: begin
        // Write the target first, then the newest slot with its forward link.
        ram_we = 1'b1;
        ram_waddr = rd_pend ? newest : tgt;
        ram_wdata.key = rd_pend ? ram_rdata.key : cur.key;
        ram_wdata.newer = tgt;
        ram_wdata.older = rd_pend ? ram_rdata.older : newest;
        ram_raddr = newest;
      end
      S_LIST: ram_raddr = walk;
      default: ram_raddr = tgt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      newest <= '0;
      oldest <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) begin
          cur <= req;
          state <= S_SCAN;
        end
        S_SCAN: state <= S_DECIDE;
        S_DECIDE: begin
          out.key_out <= '0;
          out.last <= 1'b1;
          out.status <= ST_OK;
          out.occupancy <= 7'(count);
          rd_pend <= 1'b0;
          state <= S_OUT;
          unique case (cur.kind)
            KIND_TOUCH: begin
              if (hit) begin
                if (hit_idx != newest) begin
                  tgt <= hit_idx;
                  reattach <= 1'b1;
                  state <= S_RD_O;
                end
              end else if (has_free) begin
                tgt <= free_idx;
                valid[free_idx] <= 1'b1;
                cam_key[free_idx] <= cur.key;
                count <= count + 1'b1;
                out.occupancy <= 7'(count + 1'b1);
                if (count == '0) begin
                  newest <= free_idx;
                  oldest <= free_idx;
                end
                state <= S_ATTACH;
              end else begin
                out.status <= ST_FULL;
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                out.status <= ST_EMPTY;
              end else begin
                tgt <= oldest;
                reattach <= 1'b0;
                out.key_out <= cam_key[oldest];
                valid[oldest] <= 1'b0;
                state <= S_RD_O;
              end
            end
            KIND_REMOVE: begin
              if (!hit) begin
                out.status <= ST_MISS;
              end else begin
                tgt <= hit_idx;
                reattach <= 1'b0;
                valid[hit_idx] <= 1'b0;
                state <= S_RD_O;
              end
            end
            KIND_FIND: begin
              out.status <= hit ? ST_OK : ST_MISS;
              out.key_out <= hit ? cur.key : '0;
            end
            KIND_LIST: begin
              walk <= oldest;
              if (count == '0) begin
                out.status <= ST_EMPTY;
              end else if (cur.list_limit == '0) begin
                out.status <= ST_OK;
              end else begin
                remain <= (7'(count) < cur.list_limit) ? 5'(count)
                        : (cur.list_limit > 7'(MAX_RESULTS)) ? 5'(MAX_RESULTS)
                        : 5'(cur.list_limit);
                state <= S_LIST;
              end
            end
            default: ;
          endcase
        end
        // Detach: the target record arrives now; read its links.
        S_RD_O: begin
          lnk_o <= ram_rdata.older;
          lnk_n <= ram_rdata.newer;
          if (count > CNT_W'(1)) begin
            if (tgt == newest) begin
              newest <= ram_rdata.older;
              state <= reattach ? S_ATTACH : S_OUT;
            end else if (tgt == oldest) begin
              oldest <= ram_rdata.newer;
              state <= reattach ? S_ATTACH : S_OUT;
            end else begin
              state <= S_WR_O;
            end
          end else begin
            state <= reattach ? S_ATTACH : S_OUT;
          end
          if (!reattach) begin
            count <= count - 1'b1;
            out.occupancy <= 7'(count - 1'b1);
          end
        end
        S_WR_O: state <= S_RD_N;
        S_RD_N: state <= S_WR_N;
        S_WR_N: state <= reattach ? S_ATTACH : S_OUT;
        S_ATTACH: begin
          // First visit writes the target and reads the newest slot; if the target is not newest, a second links it.
          if (rd_pend) begin
            rd_pend <= 1'b0;
            newest <= tgt;
            state <= S_OUT;
          end else if (tgt == newest) begin
            state <= S_OUT;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        S_LIST: begin
          if (rd_pend) begin
            out.key_out <= ram_rdata.key;
            out.last <= (remain == 5'd1);
            walk <= ram_rdata.newer;
            remain <= remain - 1'b1;
            rd_pend <= 1'b0;
            state <= S_OUT;
          end else begin
            rd_pend <= 1'b1;
          end
        end
        S_OUT: if (rsp_ready) begin
          state <= (cur.kind == KIND_LIST && !out.last) ? S_LIST : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/lru_checker.sv
// Port-level checker for the LRU key tracker, bound to the top level.
`timescale 1ns / 1ps
module lru_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [6:0] rsp_occupancy,
  input logic       rsp_last
);
  import lru_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken during result");
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= 7'(ENTRIES)) else $error("occupancy too large");
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == 7'(ENTRIES))
    else $error("full reported below capacity");
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0 && rsp_last)
    else $error("empty with keys held");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy))
    else $error("result dropped");
endmodule

bind lru_key_tracker_top lru_checker u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_occupancy(rsp.occupancy), .rsp_last(rsp.last)
);
